// ===== design/uer_pkg.sv =====
// Shared types, constants and codes for the ultrasonic echo ranger.
package uer_pkg;

	localparam int CNT_W  = 24;
	localparam int STEP_W = $clog2(CNT_W);
	localparam int TO_W   = 24;
	localparam int TPC_W  = 16;
	localparam int TRIG_W = 16;
	localparam int CFG_W  = 24;
	localparam int DIST_W = 24;

	typedef enum logic [1:0] {
		CFG_TIMEOUT   = 2'd0,
		CFG_TPC       = 2'd1,
		CFG_TRIG_HIGH = 2'd2,
		CFG_TRIG_GAP  = 2'd3
	} cfg_idx_t;

	localparam logic [TO_W-1:0]   RST_TIMEOUT   = TO_W'(400000);
	localparam logic [TPC_W-1:0]  RST_TPC       = TPC_W'(928);
	localparam logic [TRIG_W-1:0] RST_TRIG_HIGH = TRIG_W'(192);
	localparam logic [TRIG_W-1:0] RST_TRIG_GAP  = TRIG_W'(16);

	typedef struct packed {
		logic [TO_W-1:0]   timeout_ticks;
		logic [TPC_W-1:0]  ticks_per_cm;
		logic [TRIG_W-1:0] trig_high_ticks;
		logic [TRIG_W-1:0] trig_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic cmd;
		logic echo_level;
	} in_item_t;

	typedef struct packed {
		logic              trig_level;
		logic              busy_res;
		logic              done_res;
		logic [1:0]        status;
		logic [DIST_W-1:0] distance_cm;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_ECHO  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_GAP_PRE   = 7'b0000010,
		PH_HIGH      = 7'b0000100,
		PH_GAP_POST  = 7'b0001000,
		PH_WAIT_RISE = 7'b0010000,
		PH_MEASURE   = 7'b0100000,
		PH_DIVIDE    = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		TMR_HOLD,
		TMR_INC,
		TMR_CLEAR
	} timer_op_t;

	typedef enum logic [2:0] {
		ECHO_HOLD,
		ECHO_LOAD1,
		ECHO_INC,
		ECHO_CLEAR,
		ECHO_SHIFT
	} echo_op_t;

	typedef enum logic [1:0] {
		DIV_HOLD,
		DIV_INIT,
		DIV_STEP
	} div_op_t;

	typedef struct packed {
		logic      en;
		logic      restart;
		timer_op_t timer_op;
		echo_op_t  echo_op;
		div_op_t   div_op;
	} dp_cmd_t;

	typedef struct packed {
		logic gap_zero;
		logic inc_ge_gap;
		logic inc_ge_high;
		logic timer_ge_limit;
		logic limit_zero;
		logic echo_ge_limit;
		logic div_last;
	} dp_stat_t;

endpackage

// ===== design/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger top level: config registers, handshake and output register.
// Each input transfer is one tick of the sensor timebase and yields exactly one result
// transfer, one tick per clock cycle while the output side keeps taking results (the
// output register lets a new tick in on the cycle its held result leaves). A measurement
// runs gap, trigger pulse, gap, echo-rise wait and echo-width count, then a restoring
// divider produces one distance bit per tick, so the distance appears 24 ticks after
// the echo falls, on the result with done_res set. Write configuration only while idle.
module ultrasonic_echo_ranger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  uer_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output uer_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [uer_pkg::CFG_W-1:0]     cfg_data
);
	import uer_pkg::*;

	cfg_t      cfg_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic      accept;
	dp_cmd_t   cmd;
	dp_stat_t  stat;
	logic      trig, busy, done;
	logic [1:0]        status;
	logic [DIST_W-1:0] quotient;
	out_item_t res;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= RST_TIMEOUT;
			cfg_q.ticks_per_cm    <= RST_TPC;
			cfg_q.trig_high_ticks <= RST_TRIG_HIGH;
			cfg_q.trig_gap_ticks  <= RST_TRIG_GAP;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_data[TO_W-1:0];
				CFG_TPC:       cfg_q.ticks_per_cm    <= cfg_data[TPC_W-1:0];
				CFG_TRIG_HIGH: cfg_q.trig_high_ticks <= cfg_data[TRIG_W-1:0];
				CFG_TRIG_GAP:  cfg_q.trig_gap_ticks  <= cfg_data[TRIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	uer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.stat   (stat),
		.cmd    (cmd),
		.trig   (trig),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	uer_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.stat     (stat),
		.quotient (quotient)
	);

	always_comb begin
		res.trig_level  = trig;
		res.busy_res    = busy;
		res.done_res    = done;
		res.status      = status;
		// distance only reported on a successful finish
		res.distance_cm = (done && status == ST_OK) ? quotient : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

endmodule

// ===== design/uer_datapath.sv =====
// Ranger datapath: phase timer, echo counter and restoring divider.
module uer_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uer_pkg::cfg_t         cfg,
	input  uer_pkg::dp_cmd_t      cmd,
	output uer_pkg::dp_stat_t     stat,
	output logic [uer_pkg::DIST_W-1:0] quotient
);
	import uer_pkg::*;

	localparam int LIM_W = (CNT_W > TO_W) ? CNT_W : TO_W;

	logic [CNT_W-1:0]  timer_q, echo_q, quot_q, rem_q;
	logic [STEP_W-1:0] step_q;

	logic [LIM_W-1:0]  to_ext, max_ext;
	logic [CNT_W-1:0]  limit, timer_eff, echo_base, quot_base, rem_base;
	logic [STEP_W-1:0] step_base;
	logic [CNT_W:0]    timer_inc;
	logic [CNT_W-1:0]  rem_sh, rem_new, quot_new;
	logic              fits;

	always_comb begin
		to_ext  = LIM_W'(cfg.timeout_ticks);
		max_ext = LIM_W'({CNT_W{1'b1}});
		limit   = CNT_W'((to_ext < max_ext) ? to_ext : max_ext);

		timer_eff = cmd.restart ? '0 : timer_q;
		echo_base = cmd.restart ? '0 : echo_q;
		quot_base = cmd.restart ? '0 : quot_q;
		rem_base  = cmd.restart ? '0 : rem_q;
		step_base = cmd.restart ? '0 : step_q;
		timer_inc = {1'b0, timer_eff} + (CNT_W+1)'(1);

		// one quotient bit per tick; dividend MSB comes off the echo shift register
		rem_sh   = {rem_base[CNT_W-2:0], echo_base[CNT_W-1]};
		fits     = rem_sh >= CNT_W'(cfg.ticks_per_cm);
		rem_new  = fits ? rem_sh - CNT_W'(cfg.ticks_per_cm) : rem_sh;
		quot_new = {quot_base[CNT_W-2:0], fits};

		stat.gap_zero       = cfg.trig_gap_ticks == '0;
		stat.inc_ge_gap     = timer_inc >= (CNT_W+1)'(cfg.trig_gap_ticks);
		stat.inc_ge_high    = timer_inc >= (CNT_W+1)'(cfg.trig_high_ticks);
		stat.timer_ge_limit = timer_eff >= limit;
		stat.limit_zero     = limit == '0;
		stat.echo_ge_limit  = echo_base >= limit;
		stat.div_last       = step_base == STEP_W'(CNT_W-1);

		quotient = DIST_W'(quot_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			echo_q  <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			step_q  <= '0;
		end else if (cmd.en) begin
			case (cmd.timer_op)
				TMR_INC:   timer_q <= timer_inc[CNT_W-1:0];
				TMR_CLEAR: timer_q <= '0;
				default:   timer_q <= timer_eff;
			endcase
			case (cmd.echo_op)
				ECHO_LOAD1: echo_q <= CNT_W'(1);
				ECHO_INC:   echo_q <= echo_base + CNT_W'(1);
				ECHO_CLEAR: echo_q <= '0;
				ECHO_SHIFT: echo_q <= {echo_base[CNT_W-2:0], 1'b0};
				default:    echo_q <= echo_base;
			endcase
			case (cmd.div_op)
				DIV_INIT: begin
					quot_q <= '0;
					rem_q  <= '0;
					step_q <= '0;
				end
				DIV_STEP: begin
					quot_q <= quot_new;
					rem_q  <= rem_new;
					step_q <= stat.div_last ? '0 : step_base + STEP_W'(1);
				end
				default: begin
					quot_q <= quot_base;
					rem_q  <= rem_base;
					step_q <= step_base;
				end
			endcase
		end
	end

endmodule

// ===== design/uer_ctrl.sv =====
// Ranger controller: measurement phase sequencer and status register.
module uer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  uer_pkg::in_item_t item,
	input  uer_pkg::dp_stat_t stat,
	output uer_pkg::dp_cmd_t  cmd,
	output logic              trig,
	output logic              busy,
	output logic              done,
	output logic [1:0]        status
);
	import uer_pkg::*;

	phase_t  state_q, state_eff, state_nxt;
	status_t last_q, last_nxt;
	logic    restart;

	always_comb begin
		restart   = (state_q == PH_IDLE) && item.cmd;
		state_eff = state_q;
		if (restart) begin
			state_eff = stat.gap_zero ? PH_HIGH : PH_GAP_PRE;
		end

		state_nxt   = state_eff;
		last_nxt    = last_q;
		trig        = 1'b0;
		done        = 1'b0;
		cmd.en      = accept;
		cmd.restart = restart;
		cmd.timer_op = TMR_HOLD;
		cmd.echo_op  = ECHO_HOLD;
		cmd.div_op   = DIV_HOLD;

		unique case (state_eff)
			PH_IDLE: begin
			end
			PH_GAP_PRE: begin
				cmd.timer_op = TMR_INC;
				if (stat.inc_ge_gap) begin
					state_nxt    = PH_HIGH;
					cmd.timer_op = TMR_CLEAR;
				end
			end
			PH_HIGH: begin
				trig         = 1'b1;
				cmd.timer_op = TMR_INC;
				if (stat.inc_ge_high) begin
					state_nxt    = stat.gap_zero ? PH_WAIT_RISE : PH_GAP_POST;
					cmd.timer_op = TMR_CLEAR;
				end
			end
			PH_GAP_POST: begin
				cmd.timer_op = TMR_INC;
				if (stat.inc_ge_gap) begin
					state_nxt    = PH_WAIT_RISE;
					cmd.timer_op = TMR_CLEAR;
				end
			end
			PH_WAIT_RISE: begin
				if (item.echo_level) begin
					if (stat.limit_zero) begin
						state_nxt   = PH_IDLE;
						last_nxt    = ST_TOO_LONG;
						done        = 1'b1;
						cmd.echo_op = ECHO_CLEAR;
					end else begin
						state_nxt   = PH_MEASURE;
						cmd.echo_op = ECHO_LOAD1;
					end
				end else if (stat.timer_ge_limit) begin
					state_nxt = PH_IDLE;
					last_nxt  = ST_NO_ECHO;
					done      = 1'b1;
				end else begin
					cmd.timer_op = TMR_INC;
				end
			end
			PH_MEASURE: begin
				if (item.echo_level) begin
					if (stat.echo_ge_limit) begin
						state_nxt = PH_IDLE;
						last_nxt  = ST_TOO_LONG;
						done      = 1'b1;
					end else begin
						cmd.echo_op = ECHO_INC;
					end
				end else begin
					state_nxt  = PH_DIVIDE;
					cmd.div_op = DIV_INIT;
				end
			end
			PH_DIVIDE: begin
				cmd.div_op  = DIV_STEP;
				cmd.echo_op = ECHO_SHIFT;
				if (stat.div_last) begin
					state_nxt = PH_IDLE;
					last_nxt  = ST_OK;
					done      = 1'b1;
				end
			end
			default: begin
				state_nxt = PH_IDLE;
			end
		endcase

		busy   = state_nxt != PH_IDLE;
		status = last_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			last_q  <= ST_OK;
		end else if (accept) begin
			state_q <= state_nxt;
			last_q  <= last_nxt;
		end
	end

endmodule

// ===== tb/sv/echo_ranger_checker.sv =====
// Checker for the echo ranger: tracks config writes, predicts every result tick and compares.
`timescale 1ns / 1ps
module echo_ranger_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  uer_pkg::in_item_t         in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  uer_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [uer_pkg::CFG_W-1:0] cfg_data,
	output int                        fails,
	output int                        pending,
	output logic                      ranging
);
	import uer_pkg::*;

	// shadow of the register file
	logic [TO_W-1:0]   to_lim;
	logic [TPC_W-1:0]  per_cm;
	logic [TRIG_W-1:0] pulse_len;
	logic [TRIG_W-1:0] gap_len;

	// shadow of the ranging state
	phase_t            ph;
	logic [CNT_W-1:0]  tmr;
	logic [CNT_W-1:0]  echo_cnt;
	logic [CNT_W-1:0]  quo;
	logic [CNT_W-1:0]  rem;
	logic [STEP_W-1:0] dstep;
	status_t           last_st;

	out_item_t due_results[$];
	out_item_t want;
	int        err_cnt = 0;

	// a zero gap skips straight past its low phase
	function automatic void move_to(phase_t p);
		ph  = p;
		tmr = '0;
		if (p == PH_GAP_PRE && gap_len == 0)
			ph = PH_HIGH;
		else if (p == PH_GAP_POST && gap_len == 0)
			ph = PH_WAIT_RISE;
	endfunction

	function automatic out_item_t range_tick(in_item_t it);
		out_item_t r;
		logic      trig;
		logic      done;
		trig = 1'b0;
		done = 1'b0;
		if (ph == PH_IDLE && it.cmd) begin
			echo_cnt = '0;
			quo      = '0;
			rem      = '0;
			dstep    = '0;
			move_to(PH_GAP_PRE);
		end
		case (ph)
			PH_GAP_PRE: begin
				tmr++;
				if (tmr >= gap_len)
					move_to(PH_HIGH);
			end
			PH_HIGH: begin
				trig = 1'b1;
				tmr++;
				if (tmr >= pulse_len)
					move_to(PH_GAP_POST);
			end
			PH_GAP_POST: begin
				tmr++;
				if (tmr >= gap_len)
					move_to(PH_WAIT_RISE);
			end
			PH_WAIT_RISE: begin
				if (it.echo_level) begin
					ph       = PH_MEASURE;
					echo_cnt = CNT_W'(1);
					if (to_lim == 0) begin
						echo_cnt = '0;
						ph       = PH_IDLE;
						last_st  = ST_TOO_LONG;
						done     = 1'b1;
					end
				end else if (tmr >= to_lim) begin
					ph      = PH_IDLE;
					last_st = ST_NO_ECHO;
					done    = 1'b1;
				end else begin
					tmr++;
				end
			end
			PH_MEASURE: begin
				if (it.echo_level) begin
					if (echo_cnt >= to_lim) begin
						ph      = PH_IDLE;
						last_st = ST_TOO_LONG;
						done    = 1'b1;
					end else begin
						echo_cnt++;
					end
				end else begin
					ph    = PH_DIVIDE;
					quo   = '0;
					rem   = '0;
					dstep = '0;
				end
			end
			PH_DIVIDE: begin
				// restoring division, msb first, one quotient bit per tick
				rem = {rem[CNT_W-2:0], echo_cnt[CNT_W-1-dstep]};
				quo = {quo[CNT_W-2:0], 1'b0};
				if (rem >= per_cm) begin
					rem    = rem - per_cm;
					quo[0] = 1'b1;
				end
				dstep++;
				if (dstep >= CNT_W) begin
					dstep   = '0;
					ph      = PH_IDLE;
					last_st = ST_OK;
					done    = 1'b1;
				end
			end
			default: ph = PH_IDLE;
		endcase
		r.trig_level  = trig;
		r.busy_res    = (ph != PH_IDLE);
		r.done_res    = done;
		r.status      = last_st;
		r.distance_cm = (done && last_st == ST_OK) ? quo : '0;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_lim    = RST_TIMEOUT;
			per_cm    = RST_TPC;
			pulse_len = RST_TRIG_HIGH;
			gap_len   = RST_TRIG_GAP;
			ph        = PH_IDLE;
			tmr       = '0;
			echo_cnt  = '0;
			quo       = '0;
			rem       = '0;
			dstep     = '0;
			last_st   = ST_OK;
			due_results.delete();
			pending <= 0;
			ranging <= 1'b0;
			fails   <= err_cnt;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT:   to_lim    = cfg_data[TO_W-1:0];
					CFG_TPC:       per_cm    = cfg_data[TPC_W-1:0];
					CFG_TRIG_HIGH: pulse_len = cfg_data[TRIG_W-1:0];
					CFG_TRIG_GAP:  gap_len   = cfg_data[TRIG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_results.push_back(range_tick(in_data));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with no expectation pending");
					err_cnt++;
				end else begin
					want = due_results.pop_front();
					check_field("trig_level", 32'(want.trig_level),
						32'(out_data.trig_level));
					check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
					check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
					check_field("status", 32'(want.status), 32'(out_data.status));
					check_field("distance_cm", 32'(want.distance_cm),
						32'(out_data.distance_cm));
				end
			end
			pending <= due_results.size();
			ranging <= (ph != PH_IDLE);
			fails   <= err_cnt;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the echo ranger: clock, reset, tick stimulus, result sink and verdict.
`timescale 1ns / 1ps
module tb;
	import uer_pkg::*;

	localparam int          RAND_TICKS  = 600;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_item_t           in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;

	int                 fails;
	int                 pending;
	logic               ranging;

	int unsigned        cur_to    = 32'(RST_TIMEOUT);
	int unsigned        cur_tpc   = 32'(RST_TPC);
	int unsigned        cur_hi    = 32'(RST_TRIG_HIGH);
	int unsigned        cur_gap   = 32'(RST_TRIG_GAP);
	int                 fed       = 0;
	bit                 tx_calm   = 1'b0;
	bit                 squeeze_req = 1'b0;
	int unsigned        cyc       = 0;

	ultrasonic_echo_ranger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	echo_ranger_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.ranging   (ranging)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// result sink: random back-pressure, one long hold-off on request, then a calm stretch
	initial begin
		int calm_left;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				calm_left = 2000;
			end else begin
				out_ready <= (calm_left > 0) || ($urandom_range(99) >= 12);
				if (calm_left > 0)
					calm_left--;
			end
		end
	end

	// one tick of the sensor timebase; returns at the edge of its transfer
	task automatic push_tick(input logic c, input logic e);
		in_item_t it;
		it.cmd        = c;
		it.echo_level = e;
		if (!tx_calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		fed++;
	endtask

	// plain ticks until the measurement under way has finished; echo toggles so
	// a rise wait turns into a one-tick echo and then the divide
	task automatic run_out();
		logic e;
		e = 1'b1;
		while (ranging) begin
			push_tick(1'b0, e);
			e = !e;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0 || ranging);
	endtask

	task automatic set_ranger(input int unsigned to, input int unsigned tpc,
			input int unsigned hi, input int unsigned gap);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= CFG_W'(to);
		@(posedge clk);
		cfg_index <= CFG_TPC;
		cfg_data  <= CFG_W'(tpc);
		@(posedge clk);
		cfg_index <= CFG_TRIG_HIGH;
		cfg_data  <= CFG_W'(hi);
		@(posedge clk);
		cfg_index <= CFG_TRIG_GAP;
		cfg_data  <= CFG_W'(gap);
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_to  = to;
		cur_tpc = tpc;
		cur_hi  = hi;
		cur_gap = gap;
	endtask

	// start, ride out the trigger, then low ticks and an echo of the given width
	task automatic measure_once(input int unsigned rise_wait, input int unsigned echo_len,
			input bit rowdy);
		int unsigned pre;
		pre = 2 * cur_gap + ((cur_hi == 0) ? 1 : cur_hi) - 1;
		push_tick(1'b1, 1'($urandom_range(1)));
		repeat (pre) push_tick(rowdy ? 1'($urandom_range(1)) : 1'b0, 1'($urandom_range(1)));
		repeat (rise_wait) push_tick(rowdy ? 1'($urandom_range(1)) : 1'b0, 1'b0);
		repeat (echo_len) push_tick(rowdy ? 1'($urandom_range(1)) : 1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		run_out();
	endtask

	initial begin
		int unsigned to, tpc, hi, gap, w, h;
		int          phase_n, stop_at;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, short echo
		measure_once(3, 5, 1'b0);

		// zero gap, zero pulse width, zero divisor
		set_ranger(2, 0, 0, 0);
		measure_once(0, 1, 1'b0);
		measure_once(3, 1, 1'b0);
		measure_once(0, 3, 1'b0);
		// zero timeout fails on the first sample either way
		set_ranger(0, 'hFFFF, 1, 1);
		measure_once(0, 1, 1'b0);
		measure_once(1, 0, 1'b0);
		// starts while busy are ignored
		set_ranger(6, 3, 2, 1);
		measure_once(2, 5, 1'b1);

		stop_at = fed + RAND_TICKS;
		phase_n = 0;
		while (fed < stop_at || phase_n < 3) begin
			to = ($urandom_range(3) == 0) ? $urandom_range(200, 100) : $urandom_range(40);
			case ($urandom_range(7))
				0:       tpc = 0;
				1, 2, 3, 4: tpc = $urandom_range(8, 1);
				5:       tpc = 'hFFFF;
				default: tpc = $urandom_range('hFFFF);
			endcase
			hi  = ($urandom_range(4) == 0) ? $urandom_range(20) : $urandom_range(3);
			gap = ($urandom_range(4) == 0) ? $urandom_range(20) : $urandom_range(3);
			set_ranger(to, tpc, hi, gap);
			tx_calm = (phase_n == 2);
			repeat ($urandom_range(3, 2)) begin
				if (phase_n == 0)
					squeeze_req = 1'b1;
				if ($urandom_range(9) == 0) begin
					repeat (30) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
					run_out();
				end else begin
					w = ($urandom_range(3) != 0) ? $urandom_range(cur_to)
						: cur_to + $urandom_range(3);
					h = ($urandom_range(3) != 0) ? $urandom_range(cur_to, 1)
						: cur_to + $urandom_range(3, 1);
					measure_once(w, h, 1'($urandom_range(1)));
				end
				repeat ($urandom_range(3)) push_tick(1'b0, 1'($urandom_range(1)));
			end
			phase_n++;
		end
		tx_calm = 1'b0;

		// widest timeout and divisor
		set_ranger('hFFFFFF, 'hFFFF, 2, 1);
		measure_once(2, 4, 1'b0);
		// long echo with unit divisor gives a large distance
		set_ranger('hFFFFFF, 1, 1, 0);
		measure_once(1, 200, 1'b0);

		settle();
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
